### hw/rtl/idrm_pkg.sv
// Shared types and constants for the id range map translator.
// Used by idrm_cell and id_range_map_translator_unit; no dependencies.
package idrm_pkg;

	localparam int MAX_EXTENTS_DEF = 512;

	// item kinds on the input tuser
	typedef enum logic [2:0] {
		MODE_CLEAR  = 3'd0,
		MODE_APPEND = 3'd1,
		MODE_POINT  = 3'd2,
		MODE_MEMBER = 3'd3,
		MODE_EXTENT = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNMAPPED = 2'd1,
		ST_FULL     = 2'd2,
		ST_PASS     = 2'd3
	} status_t;

	// lookup flavor carried by the scan token
	typedef enum logic [1:0] {
		LK_POINT  = 2'd0,
		LK_MEMBER = 2'd1,
		LK_EXTENT = 2'd2
	} lookup_t;

	typedef struct packed {
		logic [31:0] up;
		logic [31:0] low;
		logic [31:0] cnt;
	} extent_t;

	// extent write broadcast to the cell row
	typedef struct packed {
		logic    en;
		logic    which;
		extent_t ext;
	} ext_wr_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic        valid;
		lookup_t     kind;
		logic        which;
		logic [31:0] key;
		logic [32:0] rend;    // key + span, no wrap
		logic        hit;
		logic [31:0] hit_up;
		logic [31:0] hit_off; // key - parent_first of the hit extent
	} token_t;

endpackage

### hw/rtl/idrm_cell.sv
// One cell of the extent row: holds entry IDX of the uid and gid tables
// and tests the passing scan token against it. Depends on idrm_pkg.
module idrm_cell #(
	parameter int MAX_EXTENTS = idrm_pkg::MAX_EXTENTS_DEF,
	parameter int IDX         = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  idrm_pkg::ext_wr_t                    wr,
	input  logic [$clog2(MAX_EXTENTS+1)-1:0]     wr_idx,
	input  logic [$clog2(MAX_EXTENTS+1)-1:0]     live_n,
	input  idrm_pkg::token_t                     tok_i,
	output idrm_pkg::token_t                     tok_o
);

	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	idrm_pkg::extent_t ent_q [2];
	idrm_pkg::token_t  tok_q;

	idrm_pkg::extent_t e;
	logic [31:0]       d_low;
	logic [31:0]       d_up;
	logic [32:0]       l_end;
	logic              in_use;
	logic              cond;
	logic              hit;

	// table entries, undefined until written
	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == MY_IDX) begin
			ent_q[wr.which] <= wr.ext;
		end
	end

	always_comb begin
		e      = ent_q[tok_i.which];
		d_low  = tok_i.key - e.low;
		d_up   = tok_i.key - e.up;
		l_end  = {1'b0, e.low} + {1'b0, e.cnt};
		in_use = MY_IDX < live_n;
		unique case (tok_i.kind)
			idrm_pkg::LK_POINT:  cond = (tok_i.key >= e.low) && (d_low < e.cnt);
			idrm_pkg::LK_MEMBER: cond = (tok_i.key >= e.up) && (d_up < e.cnt);
			idrm_pkg::LK_EXTENT: cond = (tok_i.key >= e.low) && (tok_i.rend <= l_end);
			default:             cond = 1'b0;
		endcase
		hit = tok_i.valid && !tok_i.hit && in_use && cond;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_i;
			if (hit) begin
				tok_q.hit     <= 1'b1;
				tok_q.hit_up  <= e.up;
				tok_q.hit_off <= d_low;
			end
		end
	end

	assign tok_o = tok_q;

endmodule

### hw/rtl/id_range_map_translator_unit.sv
// Top level of the id range map translator: stream ports, table counts,
// and the row of idrm_cell instances. Depends on idrm_pkg and idrm_cell.
//
// Usage:
//   Input items arrive on s_axis_*; tuser carries the item kind and table
//   select, tdata the extent bounds and the key, tlast the batch marker.
//   Each input item yields exactly one output item on m_axis_*: result id
//   in tdata, status in tuser, batch marker echoed on tlast.
//   cfg_wen/cfg_wdata write translate_enable; write it only while idle.
// Processing:
//   Clear, append, unused kinds and disabled point lookups are written
//   straight to the output register, shown in the cycle after the item is
//   taken. Point, membership and extent lookups launch a token down the
//   row of MAX_EXTENTS cells, one cell per cycle, from the launch register
//   through each cell register to the output register. One item is in work
//   at a time: no new item is taken until the token has left the cell row.
// Reset:
//   Both table counts go to zero, translate_enable to one; table contents
//   are left as they are and never read until rewritten.
// Stall:
//   A result waits in the output register while m_axis_tready is low; a
//   new item is taken in the cycle the pending result drains.
module id_range_map_translator_unit #(
	parameter int MAX_EXTENTS = idrm_pkg::MAX_EXTENTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] upper_first, [63:32] parent_first, [95:64] span, [127:96] key_id
	input  logic [127:0] s_axis_tdata,
	// [2:0] mode, [3] which_map
	input  logic [3:0]   s_axis_tuser,
	input  logic         s_axis_tlast,   // last_of_batch
	// result items
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] result_id
	output logic [31:0]  m_axis_tdata,
	// [1:0] status
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast,   // batch_done
	// configuration
	input  logic         cfg_wen,
	input  logic         cfg_wdata       // translate_enable
);

	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam logic [CW-1:0] FULL_N = CW'(MAX_EXTENTS);

	// input field split
	idrm_pkg::mode_t s_mode;
	logic            s_which;
	logic [31:0]     s_up;
	logic [31:0]     s_low;
	logic [31:0]     s_span;
	logic [31:0]     s_key;

	assign s_mode  = idrm_pkg::mode_t'(s_axis_tuser[2:0]);
	assign s_which = s_axis_tuser[3];
	assign s_up    = s_axis_tdata[31:0];
	assign s_low   = s_axis_tdata[63:32];
	assign s_span  = s_axis_tdata[95:64];
	assign s_key   = s_axis_tdata[127:96];

	// control and output state
	logic              en_q;          // translate_enable
	logic [CW-1:0]     cnt_q [2];     // extents per table
	logic              busy_q;        // token in the row
	logic              pend_last_q;   // batch marker of the lookup in work
	logic              out_valid_q;
	logic [31:0]       res_q;
	idrm_pkg::status_t st_q;
	logic              last_q;
	idrm_pkg::token_t  launch_q;

	logic              accept;
	logic              drain;
	logic              full;
	logic              is_lookup;
	logic              is_clear;
	idrm_pkg::lookup_t lk_kind;
	idrm_pkg::status_t imm_st;
	idrm_pkg::ext_wr_t wr;

	idrm_pkg::token_t  tok_w [MAX_EXTENTS+1];
	logic [MAX_EXTENTS:0] chain_vld;
	idrm_pkg::token_t  end_tok;
	logic [CW-1:0]     live_n;

	assign drain         = out_valid_q && m_axis_tready;
	assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = cnt_q[s_which] == FULL_N;

	// decode of the incoming item
	always_comb begin
		is_lookup = 1'b0;
		is_clear  = 1'b0;
		lk_kind   = idrm_pkg::LK_POINT;
		imm_st    = idrm_pkg::ST_OK;
		wr.en     = 1'b0;
		wr.which  = s_which;
		wr.ext    = '{up: s_up, low: s_low, cnt: s_span};
		unique case (s_mode)
			idrm_pkg::MODE_CLEAR: begin
				is_clear = accept;
			end
			idrm_pkg::MODE_APPEND: begin
				if (full) begin
					imm_st = idrm_pkg::ST_FULL;
				end else begin
					wr.en = accept;
				end
			end
			idrm_pkg::MODE_POINT: begin
				if (!en_q) begin
					imm_st = idrm_pkg::ST_PASS;
				end else begin
					is_lookup = 1'b1;
					lk_kind   = idrm_pkg::LK_POINT;
				end
			end
			idrm_pkg::MODE_MEMBER: begin
				is_lookup = 1'b1;
				lk_kind   = idrm_pkg::LK_MEMBER;
			end
			idrm_pkg::MODE_EXTENT: begin
				is_lookup = 1'b1;
				lk_kind   = idrm_pkg::LK_EXTENT;
			end
			default: begin
				imm_st = idrm_pkg::ST_UNMAPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
		end else if (cfg_wen) begin
			en_q <= cfg_wdata;
		end
	end

	// table counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (is_clear) begin
			cnt_q[s_which] <= '0;
		end else if (wr.en) begin
			cnt_q[s_which] <= cnt_q[s_which] + CW'(1);
		end
	end

	// token launch register; rend is formed here, ahead of the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else if (accept && is_lookup) begin
			launch_q.valid   <= 1'b1;
			launch_q.kind    <= lk_kind;
			launch_q.which   <= s_which;
			launch_q.key     <= s_key;
			launch_q.rend    <= {1'b0, s_key} + {1'b0, s_span};
			launch_q.hit     <= 1'b0;
			launch_q.hit_up  <= '0;
			launch_q.hit_off <= '0;
		end else begin
			launch_q.valid <= 1'b0;
		end
	end

	// counts are stable while a token is in the row
	assign live_n   = cnt_q[launch_q.which];
	assign tok_w[0] = launch_q;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_cell
			idrm_cell #(
				.MAX_EXTENTS(MAX_EXTENTS),
				.IDX        (gi)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.wr    (wr),
				.wr_idx(cnt_q[s_which]),
				.live_n(live_n),
				.tok_i (tok_w[gi]),
				.tok_o (tok_w[gi+1])
			);
		end
		for (gi = 0; gi <= MAX_EXTENTS; gi++) begin : g_vld
			assign chain_vld[gi] = tok_w[gi].valid;
		end
	endgenerate

	assign end_tok = tok_w[MAX_EXTENTS];

	// busy flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (is_lookup) begin
					busy_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
			if (end_tok.valid) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end
		end
	end

	// result payload; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_last_q <= s_axis_tlast;
			if (!is_lookup) begin
				res_q  <= s_key;
				st_q   <= imm_st;
				last_q <= s_axis_tlast;
			end
		end
		if (end_tok.valid) begin
			last_q <= pend_last_q;
			if (end_tok.hit) begin
				st_q <= idrm_pkg::ST_OK;
			end else begin
				st_q <= idrm_pkg::ST_UNMAPPED;
			end
			// point and extent hits translate; membership echoes the key
			if (end_tok.hit && end_tok.kind != idrm_pkg::LK_MEMBER) begin
				res_q <= end_tok.hit_up + end_tok.hit_off;
			end else begin
				res_q <= end_tok.key;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;
	assign m_axis_tuser  = st_q;
	assign m_axis_tlast  = last_q;

	// at most one scan token anywhere in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one token in the cell row");

	// a token leaves the row only while a lookup is outstanding
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		end_tok.valid |-> busy_q)
		else $error("token left the row with no lookup in work");

	// the output register is free when the lookup result arrives
	a_end_free: assert property (@(posedge clk) disable iff (!arst_n)
		end_tok.valid |-> !out_valid_q)
		else $error("lookup result would overwrite a pending result");

	// table counts stay within the row length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= FULL_N) && (cnt_q[1] <= FULL_N))
		else $error("table count beyond capacity");

	// a launched lookup keeps the block busy the cycle after
	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q.valid |-> busy_q)
		else $error("token launched while not busy");

endmodule
